// File: hdl/lcc_pkg.sv
// Shared types and constants for the 3D line clipper.
// Used by lcc_div_pipe, line_clipper_cube_unit and lcc_checker.
package lcc_pkg;

  localparam int COORD_W = 32;               // Q-format coordinate width
  localparam int DIFF_W  = 34;               // end - start, bound numerators
  localparam int MAG_W   = 33;               // magnitudes of num and den
  localparam int RGB_W   = 24;
  localparam int CH_W    = 8;
  localparam int NAXIS   = 3;
  localparam int NTEST   = 6;
  localparam int T_BITS  = 30;               // clip parameter, 1.0 = 2^T_BITS
  localparam int T_W     = 32;               // signed working width of t

  localparam int DIV_STEP   = 2;             // quotient bits per divider stage
  localparam int DIV_STAGES = T_BITS / DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  // Split of the difference for the interpolation multiply.
  localparam int LO_W = 17;
  localparam int HI_W = DIFF_W - LO_W;
  localparam int PL_W = T_BITS + 1 + LO_W;
  localparam int PH_W = T_BITS + 2 + HI_W;
  localparam int PC_W = T_BITS + 2 + CH_W + 1;
  localparam int PW   = PH_W + LO_W + 2;

  // Edges from an accepting edge to the edge that takes its result.
  localparam int ACCEPT_TO_DONE = DIV_LAT + 6;

  typedef struct packed {
    logic [MAG_W:0]   rem;
    logic [T_BITS:0]  quo;
    logic [MAG_W-1:0] den;
    logic             over;
  } div_stage_t;

  typedef struct packed {
    logic den_pos;
    logic den_neg;
    logic num_pos;
    logic num_zero;
    logic mism;
  } test_t;

  typedef struct packed {
    logic [NAXIS-1:0][COORD_W-1:0] s;
    logic [NAXIS-1:0][DIFF_W-1:0]  d;
    logic [RGB_W-1:0]              ca;
    logic [RGB_W-1:0]              cb;
    test_t [NTEST-1:0]             tst;
  } side_t;

  typedef struct packed {
    logic                  vis;
    logic signed [T_W-1:0] te;
    logic signed [T_W-1:0] tl;
  } clip_t;

endpackage

// File: hdl/lcc_div_pipe.sv
// Pipelined restoring divider: floor(num * 2^30 / den) for num <= den.
// Flags num > den. Depends on lcc_pkg.
module lcc_div_pipe (
  input  logic                        clk,
  input  logic [lcc_pkg::MAG_W-1:0]   num_mag,
  input  logic [lcc_pkg::MAG_W-1:0]   den_mag,
  output logic [lcc_pkg::T_BITS:0]    quo,
  output logic                        over
);

  localparam int MW = lcc_pkg::MAG_W;
  localparam int TB = lcc_pkg::T_BITS;
  localparam int NS = lcc_pkg::DIV_STAGES;

  lcc_pkg::div_stage_t stg [0:NS];
  lcc_pkg::div_stage_t stg_next [0:NS];

  always_comb begin : step_logic
    logic [MW:0] r;
    logic [TB:0] q;
    logic        ge;
    ge = (num_mag >= den_mag);
    stg_next[0].den  = den_mag;
    stg_next[0].over = ge && (num_mag != den_mag);
    stg_next[0].rem  = ge ? {1'b0, num_mag - den_mag} : {1'b0, num_mag};
    stg_next[0].quo  = {{TB{1'b0}}, ge};
    for (int k = 1; k <= NS; k++) begin
      r = stg[k-1].rem;
      q = stg[k-1].quo;
      for (int j = 0; j < lcc_pkg::DIV_STEP; j++) begin
        r = {r[MW-1:0], 1'b0};
        if (r >= {1'b0, stg[k-1].den}) begin
          r = r - {1'b0, stg[k-1].den};
          q = {q[TB-1:0], 1'b1};
        end else begin
          q = {q[TB-1:0], 1'b0};
        end
      end
      stg_next[k].rem  = r;
      stg_next[k].quo  = q;
      stg_next[k].den  = stg[k-1].den;
      stg_next[k].over = stg[k-1].over;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NS; k++) begin
      stg[k] <= stg_next[k];
    end
  end

  assign quo  = stg[NS].quo;
  assign over = stg[NS].over;

endmodule

// File: hdl/line_clipper_cube_unit.sv
// Liang-Barsky clipping of a 3D segment against the cube [-1,1]^3.
// Path: input register, bound setup, dividers, boundary tests, products, output register.
// Throughput: one segment per cycle; busy stays low, done strobes for one cycle.
// Depth is set by the six parallel dividers, two quotient bits per stage.
// Reset (rst, synchronous) clears all valid bits; results in flight are dropped.
// Depends on lcc_pkg and lcc_div_pipe.
module line_clipper_cube_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic [23:0]        start_rgb,
  input  logic [23:0]        end_rgb,
  output logic               done,
  output logic               visible,
  output logic signed [31:0] clip_start_x,
  output logic signed [31:0] clip_start_y,
  output logic signed [31:0] clip_start_z,
  output logic signed [31:0] clip_end_x,
  output logic signed [31:0] clip_end_y,
  output logic signed [31:0] clip_end_z,
  output logic [23:0]        clip_start_rgb,
  output logic [23:0]        clip_end_rgb
);

  localparam int CW   = lcc_pkg::COORD_W;
  localparam int DW   = lcc_pkg::DIFF_W;
  localparam int MW   = lcc_pkg::MAG_W;
  localparam int TB   = lcc_pkg::T_BITS;
  localparam int TW   = lcc_pkg::T_W;
  localparam int NA   = lcc_pkg::NAXIS;
  localparam int NT   = lcc_pkg::NTEST;
  localparam int CHW  = lcc_pkg::CH_W;
  localparam int LOW  = lcc_pkg::LO_W;
  localparam int PLW  = lcc_pkg::PL_W;
  localparam int PHW  = lcc_pkg::PH_W;
  localparam int PCW  = lcc_pkg::PC_W;
  localparam int PWW  = lcc_pkg::PW;
  localparam int DLAT = lcc_pkg::DIV_LAT;

  localparam logic signed [DW-1:0]  UNIT   = DW'(1) <<< COORD_FRAC_BITS;
  localparam logic signed [TW-1:0]  T_ONE  = TW'(1) <<< TB;
  localparam logic signed [TW-1:0]  T_PAST = T_ONE + TW'(1);
  localparam logic signed [TW-1:0]  T_NEG  = -TW'(1);
  localparam logic signed [PWW-1:0] HALF_W = PWW'(1) <<< (TB - 1);
  localparam logic signed [PCW-1:0] HALF_C = PCW'(1) <<< (TB - 1);

  function automatic lcc_pkg::test_t test_flags(logic signed [DW-1:0] num,
                                                logic signed [DW-1:0] den);
    lcc_pkg::test_t f;
    f.num_zero = (num == '0);
    f.num_pos  = !num[DW-1] && !f.num_zero;
    f.den_neg  = den[DW-1];
    f.den_pos  = !den[DW-1] && (den != '0);
    f.mism     = num[DW-1] != den[DW-1];
    return f;
  endfunction

  function automatic logic [MW-1:0] mag(logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = v[DW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  function automatic lcc_pkg::clip_t bound_step(lcc_pkg::test_t f, logic [TB:0] q,
                                                logic ov, lcc_pkg::clip_t c);
    lcc_pkg::clip_t        r;
    logic signed [TW-1:0]  t;
    r = c;
    if (f.num_zero)  t = '0;
    else if (f.mism) t = T_NEG;
    else if (ov)     t = T_PAST;
    else             t = signed'(TW'(q));
    if (c.vis) begin
      if (f.den_pos) begin
        if (t > c.tl)      r.vis = 1'b0;
        else if (t > c.te) r.te  = t;
      end else if (f.den_neg) begin
        if (t < c.te)      r.vis = 1'b0;
        else if (t < c.tl) r.tl  = t;
      end else if (f.num_pos) begin
        r.vis = 1'b0;
      end
    end
    return r;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register
  logic                     in_valid;
  logic [NA-1:0][CW-1:0]    in_s;
  logic [NA-1:0][CW-1:0]    in_e;
  logic [23:0]              in_ca;
  logic [23:0]              in_cb;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_s  <= {start_z, start_y, start_x};
      in_e  <= {end_z, end_y, end_x};
      in_ca <= start_rgb;
      in_cb <= end_rgb;
    end
  end

  // Bound numerators and denominators
  lcc_pkg::side_t  prep_side_next;
  logic [MW-1:0]   un_next [NT];
  logic [MW-1:0]   ud_next [NT];

  always_comb begin : prep_logic
    logic signed [DW-1:0] s34;
    logic signed [DW-1:0] e34;
    logic signed [DW-1:0] d34;
    logic signed [DW-1:0] num_lo;
    logic signed [DW-1:0] num_hi;
    prep_side_next.ca = in_ca;
    prep_side_next.cb = in_cb;
    for (int a = 0; a < NA; a++) begin
      s34    = signed'({{(DW-CW){in_s[a][CW-1]}}, in_s[a]});
      e34    = signed'({{(DW-CW){in_e[a][CW-1]}}, in_e[a]});
      d34    = e34 - s34;
      num_lo = -UNIT - s34;
      num_hi = s34 - UNIT;
      prep_side_next.s[a]       = in_s[a];
      prep_side_next.d[a]       = d34;
      prep_side_next.tst[2*a]   = test_flags(num_lo, d34);
      prep_side_next.tst[2*a+1] = test_flags(num_hi, -d34);
      un_next[2*a]   = mag(num_lo);
      ud_next[2*a]   = mag(d34);
      un_next[2*a+1] = mag(num_hi);
      ud_next[2*a+1] = mag(d34);
    end
  end

  logic            prep_valid;
  lcc_pkg::side_t  prep_side;
  logic [MW-1:0]   prep_un [NT];
  logic [MW-1:0]   prep_ud [NT];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else begin
      prep_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prep_side <= prep_side_next;
    for (int i = 0; i < NT; i++) begin
      prep_un[i] <= un_next[i];
      prep_ud[i] <= ud_next[i];
    end
  end

  // Six dividers with side data delayed alongside
  logic [TB:0] div_quo  [NT];
  logic        div_over [NT];

  for (genvar g = 0; g < NT; g++) begin : g_div
    lcc_div_pipe u_div (
      .clk     (clk),
      .num_mag (prep_un[g]),
      .den_mag (prep_ud[g]),
      .quo     (div_quo[g]),
      .over    (div_over[g])
    );
  end

  lcc_pkg::side_t  side_dly  [DLAT];
  logic [DLAT-1:0] valid_dly;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dly <= '0;
    end else begin
      valid_dly <= {valid_dly[DLAT-2:0], prep_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_dly[0] <= prep_side;
    for (int k = 1; k < DLAT; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
  end

  // Boundary tests: x and half of y, then the rest
  lcc_pkg::clip_t  dec1_clip_next;
  lcc_pkg::clip_t  dec2_clip_next;
  logic            dec1_valid;
  lcc_pkg::side_t  dec1_side;
  lcc_pkg::clip_t  dec1_clip;
  logic [TB:0]     dec1_quo  [NT/2];
  logic            dec1_over [NT/2];
  logic            dec2_valid;
  lcc_pkg::side_t  dec2_side;
  lcc_pkg::clip_t  dec2_clip;

  always_comb begin
    dec1_clip_next.vis = 1'b1;
    dec1_clip_next.te  = '0;
    dec1_clip_next.tl  = T_ONE;
    for (int i = 0; i < NT/2; i++) begin
      dec1_clip_next = bound_step(side_dly[DLAT-1].tst[i], div_quo[i], div_over[i],
                                  dec1_clip_next);
    end
    dec2_clip_next = dec1_clip;
    for (int i = 0; i < NT/2; i++) begin
      dec2_clip_next = bound_step(dec1_side.tst[NT/2+i], dec1_quo[i], dec1_over[i],
                                  dec2_clip_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec1_valid <= 1'b0;
      dec2_valid <= 1'b0;
    end else begin
      dec1_valid <= valid_dly[DLAT-1];
      dec2_valid <= dec1_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec1_side <= side_dly[DLAT-1];
    dec1_clip <= dec1_clip_next;
    for (int i = 0; i < NT/2; i++) begin
      dec1_quo[i]  <= div_quo[NT/2+i];
      dec1_over[i] <= div_over[NT/2+i];
    end
    dec2_side <= dec1_side;
    dec2_clip <= dec2_clip_next;
  end

  // Interpolation products
  logic [PLW-1:0]        pl_next [2][NA];
  logic signed [PHW-1:0] ph_next [2][NA];
  logic signed [PCW-1:0] pc_next [2][NA];

  always_comb begin : mul_logic
    logic [TB:0]           tt;
    logic signed [CHW:0]   dc;
    for (int e = 0; e < 2; e++) begin
      tt = (e == 0) ? dec2_clip.te[TB:0] : dec2_clip.tl[TB:0];
      for (int a = 0; a < NA; a++) begin
        pl_next[e][a] = PLW'(tt) * PLW'(dec2_side.d[a][LOW-1:0]);
        ph_next[e][a] = PHW'(signed'({1'b0, tt})) *
                        PHW'(signed'(dec2_side.d[a][DW-1:LOW]));
        dc = signed'({1'b0, dec2_side.cb[CHW*a +: CHW]}) -
             signed'({1'b0, dec2_side.ca[CHW*a +: CHW]});
        pc_next[e][a] = PCW'(signed'({1'b0, tt})) * PCW'(dc);
      end
    end
  end

  logic                  mul_valid;
  logic                  mul_vis;
  logic [NA-1:0][CW-1:0] mul_s;
  logic [23:0]           mul_ca;
  logic [PLW-1:0]        mul_pl [2][NA];
  logic signed [PHW-1:0] mul_ph [2][NA];
  logic signed [PCW-1:0] mul_pc [2][NA];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= dec2_valid;
    end
  end

  always_ff @(posedge clk) begin
    mul_vis <= dec2_clip.vis;
    mul_s   <= dec2_side.s;
    mul_ca  <= dec2_side.ca;
    mul_pl  <= pl_next;
    mul_ph  <= ph_next;
    mul_pc  <= pc_next;
  end

  // Round, add the start value, zero a rejected segment
  logic [NA-1:0][CW-1:0] res_next [2];
  logic [23:0]           rgb_next [2];

  always_comb begin : sum_logic
    logic signed [PWW-1:0] p;
    logic signed [PWW-1:0] q;
    logic signed [PCW-1:0] pc;
    logic signed [PCW-1:0] qc;
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < NA; a++) begin
        p = (PWW'(mul_ph[e][a]) <<< LOW) + signed'(PWW'(mul_pl[e][a])) + HALF_W;
        q = p >>> TB;
        res_next[e][a] = mul_vis ? mul_s[a] + q[CW-1:0] : '0;
        pc = mul_pc[e][a] + HALF_C;
        qc = pc >>> TB;
        rgb_next[e][CHW*a +: CHW] = mul_vis ? mul_ca[CHW*a +: CHW] + qc[CHW-1:0] : '0;
      end
    end
  end

  logic [NA-1:0][CW-1:0] out_res [2];
  logic [23:0]           out_rgb [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      visible <= 1'b0;
    end else begin
      done    <= mul_valid;
      visible <= mul_valid && mul_vis;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= res_next;
    out_rgb <= rgb_next;
  end

  assign clip_start_x   = signed'(out_res[0][0]);
  assign clip_start_y   = signed'(out_res[0][1]);
  assign clip_start_z   = signed'(out_res[0][2]);
  assign clip_end_x     = signed'(out_res[1][0]);
  assign clip_end_y     = signed'(out_res[1][1]);
  assign clip_end_z     = signed'(out_res[1][2]);
  assign clip_start_rgb = out_rgb[0];
  assign clip_end_rgb   = out_rgb[1];

endmodule

// File: hdl/lcc_checker.sv
// Port-level checks for line_clipper_cube_unit, attached by bind.
// Depends on lcc_pkg.
module lcc_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               visible,
  input logic signed [31:0] clip_start_x,
  input logic signed [31:0] clip_start_y,
  input logic signed [31:0] clip_start_z,
  input logic signed [31:0] clip_end_x,
  input logic signed [31:0] clip_end_y,
  input logic signed [31:0] clip_end_z,
  input logic [23:0]        clip_start_rgb,
  input logic [23:0]        clip_end_rgb
);

  localparam int LAT = lcc_pkg::ACCEPT_TO_DONE;

  // Every transfer in comes out after the fixed latency.
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted segment produced no result");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transfer in");

  a_vis_with_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> !visible)
    else $error("visible without done");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !visible) |-> (clip_start_x == 0 && clip_start_y == 0 &&
      clip_start_z == 0 && clip_end_x == 0 && clip_end_y == 0 && clip_end_z == 0 &&
      clip_start_rgb == 0 && clip_end_rgb == 0))
    else $error("rejected segment with nonzero fields");

endmodule

bind line_clipper_cube_unit lcc_port_checks u_lcc_checker (.*);
